### rtl/bps_pkg.sv
// -----------------------------------------------------------------------------
// bps_pkg
// Shared constants, request/result types and sequencer states for the
// bilinear patch sampler.
// -----------------------------------------------------------------------------
package bps_pkg;

    // image and arithmetic configuration
    localparam int IMAGE_WIDTH  = 512;
    localparam int IMAGE_HEIGHT = 512;
    localparam int FRAC_BITS    = 8;
    localparam int MAX_RADIUS   = 3;

    // fixed field widths
    localparam int COORD_W  = 17;
    localparam int COL_W    = 9;
    localparam int ROW_W    = 9;
    localparam int PIX_W    = 8;
    localparam int VALUE_W  = 24;
    localparam int RADIUS_W = 2;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 2'd2;

    // derived widths
    localparam int INT_W  = COORD_W - FRAC_BITS;
    localparam int POS_W  = INT_W + 2;
    localparam int RAD_W  = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
    localparam int OFF_W  = RAD_W + 1;
    localparam int WGT_W  = 2 * FRAC_BITS + 1;
    localparam int ACC_W  = 2 * FRAC_BITS + PIX_W;
    localparam int DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    // scaling of the weighted sum to 16 fraction bits
    localparam int SHL = (2 * FRAC_BITS <= 16) ? 16 - 2 * FRAC_BITS : 0;
    localparam int SHR = (2 * FRAC_BITS > 16) ? 2 * FRAC_BITS - 16 : 0;
    localparam int RND = (SHR > 0) ? (1 << (SHR - 1)) : 0;

    localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [COL_W-1:0]   pixel_col;
        logic [ROW_W-1:0]   pixel_row;
        logic [PIX_W-1:0]   pixel_value;
        logic [COORD_W-1:0] centre_x;
        logic [COORD_W-1:0] centre_y;
    } t_req;

    typedef struct packed {
        logic [VALUE_W-1:0] sample_value;
        logic               outside_image;
        logic               last_sample;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_FINISH
    } t_state;

endpackage

### rtl/bps_ram.sv
// -----------------------------------------------------------------------------
// bps_ram
// Generic single-write, single-read memory with a registered read port.
// -----------------------------------------------------------------------------
module bps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bilinear_patch_sampler.sv
// -----------------------------------------------------------------------------
// bilinear_patch_sampler
// Pixel store with a bilinear patch sampler: write requests load pixels,
// sample requests emit one blended value per position of a square patch.
// -----------------------------------------------------------------------------
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------------
//  request   | start, busy                | i_req (t_req)
//  result    | o_res_strobe (one cycle)   | o_res (t_res)
//  config    | i_cfg_valid, o_cfg_ready   | i_cfg_data (patch radius)
//
//  a write request lands its pixel in the store at accept. a sample request
//  walks (2r+1)^2 positions: a position whose four neighbours are inside the
//  image passes four reads on the single store read port, a drain state for
//  the read latency and a finish state that scales; a position outside is
//  answered from the read state. busy falls in the cycle that shows the last
//  result. reset restores the radius to 2; the store is not cleared.
//  results are strobed for one cycle and cannot be held off.
// -----------------------------------------------------------------------------
module bilinear_patch_sampler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  bps_pkg::t_req                   i_req,
    output logic                            o_res_strobe,
    output bps_pkg::t_res                   o_res,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bps_pkg::RADIUS_W-1:0]    i_cfg_data
);
    import bps_pkg::*;

    t_state                   r_state, n_state;
    logic [RADIUS_W-1:0]      r_radius;
    logic [INT_W-1:0]         r_ix, r_iy;
    logic [FRAC_BITS-1:0]     r_fx, r_fy;
    logic signed [OFF_W-1:0]  r_rad, n_rad;
    logic signed [OFF_W-1:0]  r_dx, n_dx;
    logic signed [OFF_W-1:0]  r_dy, n_dy;
    logic [1:0]               r_nbr, n_nbr;
    logic [WGT_W-1:0]         r_weight, n_weight;
    logic                     r_acc_vld, n_acc_vld;
    logic [ACC_W-1:0]         r_acc;
    logic                     r_res_strobe, n_res_strobe;
    t_res                     r_res, n_res;

    logic                     acc_clr;
    logic                     accept_sample;
    logic [RAD_W-1:0]         rad_eff;
    logic signed [POS_W-1:0]  pos_x0, pos_x1, pos_y0, pos_y1;
    logic signed [POS_W-1:0]  col_sel, row_sel;
    logic                     pos_out;
    logic                     pos_last;
    logic [FRAC_BITS:0]       wx, wy;
    logic [2*FRAC_BITS+1:0]   wprod;
    logic [WGT_W+PIX_W-1:0]   term;
    logic [31:0]              rnd_sum;
    logic [VALUE_W-1:0]       scaled;

    logic                     ram_we, ram_re;
    logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
    logic [PIX_W-1:0]         ram_rdata;

    // pixel store
    bps_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_req.pixel_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = !busy;

    // write requests go straight to the store, out-of-image writes dropped
    assign ram_we = start && !busy && (i_req.cmd == CMD_WRITE)
                    && (32'(i_req.pixel_col) < IMAGE_WIDTH)
                    && (32'(i_req.pixel_row) < IMAGE_HEIGHT);
    assign ram_waddr = ADDR_W'(i_req.pixel_row) * ADDR_W'(IMAGE_WIDTH)
                       + ADDR_W'(i_req.pixel_col);

    assign accept_sample = start && !busy && (i_req.cmd == CMD_SAMPLE);

    // radius saturated to the supported maximum
    assign rad_eff = (32'(r_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
                                                  : RAD_W'(r_radius);

    // neighbour geometry for the current offset
    assign pos_x0  = $signed({2'b00, r_ix}) + POS_W'(r_dx);
    assign pos_y0  = $signed({2'b00, r_iy}) + POS_W'(r_dy);
    assign pos_x1  = pos_x0 + POS_W'(r_fx != '0);
    assign pos_y1  = pos_y0 + POS_W'(r_fy != '0);
    assign pos_out = pos_x0[POS_W-1] || pos_y0[POS_W-1]
                     || (32'(pos_x1) >= IMAGE_WIDTH)
                     || (32'(pos_y1) >= IMAGE_HEIGHT);
    assign pos_last = (r_dx == r_rad) && (r_dy == r_rad);

    // neighbour order: bit 0 picks the right column, bit 1 the lower row
    assign col_sel   = r_nbr[0] ? pos_x1 : pos_x0;
    assign row_sel   = r_nbr[1] ? pos_y1 : pos_y0;
    assign ram_raddr = ADDR_W'(unsigned'(row_sel)) * ADDR_W'(IMAGE_WIDTH)
                       + ADDR_W'(unsigned'(col_sel));

    // bilinear weight of the neighbour being read
    assign wx       = r_nbr[0] ? {1'b0, r_fx} : FRAC_ONE - {1'b0, r_fx};
    assign wy       = r_nbr[1] ? {1'b0, r_fy} : FRAC_ONE - {1'b0, r_fy};
    assign wprod    = wx * wy;
    assign n_weight = wprod[WGT_W-1:0];

    // weighted pixel arriving from the store
    assign term = r_weight * ram_rdata;

    // scale to 16 fraction bits
    assign rnd_sum = 32'(r_acc) + 32'(RND);
    assign scaled  = VALUE_W'((rnd_sum >> SHR) << SHL);

    // sequencer: next state and outputs
    always_comb begin
        n_state      = r_state;
        n_rad        = r_rad;
        n_dx         = r_dx;
        n_dy         = r_dy;
        n_nbr        = r_nbr;
        n_acc_vld    = 1'b0;
        acc_clr      = 1'b0;
        ram_re       = 1'b0;
        n_res_strobe = 1'b0;
        n_res        = r_res;

        case (r_state)
            ST_IDLE: begin
                if (accept_sample) begin
                    n_rad   = $signed({1'b0, rad_eff});
                    n_dx    = -$signed({1'b0, rad_eff});
                    n_dy    = -$signed({1'b0, rad_eff});
                    n_nbr   = 2'd0;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (pos_out) begin
                    n_res_strobe        = 1'b1;
                    n_res.sample_value  = '0;
                    n_res.outside_image = 1'b1;
                    n_res.last_sample   = pos_last;
                end else begin
                    ram_re    = 1'b1;
                    n_acc_vld = 1'b1;
                    acc_clr   = (r_nbr == 2'd0);
                    n_nbr     = r_nbr + 2'd1;
                    if (r_nbr == 2'd3) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                n_res_strobe        = 1'b1;
                n_res.sample_value  = scaled;
                n_res.outside_image = 1'b0;
                n_res.last_sample   = pos_last;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // step to the next patch position after a result
        if (n_res_strobe) begin
            n_nbr = 2'd0;
            if (r_dy == r_rad) begin
                n_dy = -r_rad;
                n_dx = r_dx + OFF_W'(1);
            end else begin
                n_dy = r_dy + OFF_W'(1);
            end
            n_state = pos_last ? ST_IDLE : ST_READ;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_radius     <= RADIUS_RESET;
            r_acc_vld    <= 1'b0;
            r_res_strobe <= 1'b0;
            r_nbr        <= 2'd0;
        end else begin
            r_state      <= n_state;
            r_acc_vld    <= n_acc_vld;
            r_res_strobe <= n_res_strobe;
            r_nbr        <= n_nbr;
            if (i_cfg_valid && o_cfg_ready) begin
                r_radius <= i_cfg_data;
            end
        end
    end

    // patch geometry and datapath registers
    always_ff @(posedge i_clk) begin
        r_rad    <= n_rad;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_weight <= n_weight;
        r_res    <= n_res;
        if (accept_sample) begin
            r_ix <= i_req.centre_x[COORD_W-1:FRAC_BITS];
            r_iy <= i_req.centre_y[COORD_W-1:FRAC_BITS];
            r_fx <= i_req.centre_x[FRAC_BITS-1:0];
            r_fy <= i_req.centre_y[FRAC_BITS-1:0];
        end
        if (acc_clr) begin
            r_acc <= '0;
        end else if (r_acc_vld) begin
            r_acc <= r_acc + term[ACC_W-1:0];
        end
    end

    assign o_res_strobe = r_res_strobe;
    assign o_res        = r_res;

    // checks
    a_out_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && o_res.outside_image |-> o_res.sample_value == '0)
        else $error("outside result with nonzero value");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept_sample |=> busy)
        else $error("sample request did not start the sequencer");

    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("store written while the sequencer reads");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && o_res.last_sample |-> !busy)
        else $error("busy after the last result of a patch");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> o_res.sample_value <= VALUE_W'(255 << 16))
        else $error("blended value above full scale");

endmodule

### test/tb_bilinear_patch_sampler.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_bilinear_patch_sampler
// Self-checking bench for the bilinear patch sampler. Pixel writes and patch
// sample requests go in through the start/busy port. A behavioral model of
// the pixel store and the blend predicts every strobed result, and each result
// is compared field by field in arrival order. Every pixel that a sample will
// read is loaded first. The patch radius is swept over all its settings.
// -----------------------------------------------------------------------------
module tb_bilinear_patch_sampler;
    import bps_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int GAP_PERCENT   = 9;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_req                i_req;
    logic                o_res_strobe;
    t_res                o_res;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [RADIUS_W-1:0] i_cfg_data;

    // behavioral copy of the store and the radius register
    logic [PIX_W-1:0]    pixel_mirror [DEPTH];
    bit                  pixel_loaded [DEPTH];
    logic [RADIUS_W-1:0] radius_reg = RADIUS_RESET;

    t_res expected_blends [$];
    t_res got_res;
    t_res want_res;

    int  error_count     = 0;
    int  request_count   = 0;
    int  write_count     = 0;
    int  sample_count    = 0;
    int  results_checked = 0;
    int  cycle_count     = 0;
    bit  gaps_on         = 1'b1;
    bit  [MAX_RADIUS:0] radius_used = '0;

    bilinear_patch_sampler i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // locate the four neighbours of a fixed point position
    function automatic bit neighbour_cell(input longint px, input longint py,
                                          output int x0, output int y0,
                                          output int x1, output int y1,
                                          output longint fx, output longint fy);
        longint unit;
        unit = longint'(1) << FRAC_BITS;
        x0 = 0; y0 = 0; x1 = 0; y1 = 0; fx = 0; fy = 0;
        if (px < 0 || py < 0)
            return 1'b0;
        x0 = int'(px >> FRAC_BITS);
        y0 = int'(py >> FRAC_BITS);
        fx = px & (unit - 1);
        fy = py & (unit - 1);
        x1 = (fx != 0) ? x0 + 1 : x0;
        y1 = (fy != 0) ? y0 + 1 : y0;
        return (x1 < IMAGE_WIDTH && y1 < IMAGE_HEIGHT);
    endfunction

    function automatic longint mirror_pixel(input int col, input int row);
        return longint'(pixel_mirror[row * IMAGE_WIDTH + col]);
    endfunction

    // bilinear blend scaled to 16 fraction bits
    function automatic t_res blend_point(input longint px, input longint py);
        t_res   res;
        int     x0, y0, x1, y1;
        longint fx, fy, unit, sum;
        res = '0;
        res.outside_image = 1'b1;
        if (!neighbour_cell(px, py, x0, y0, x1, y1, fx, fy))
            return res;
        unit = longint'(1) << FRAC_BITS;
        sum = (unit - fx) * (unit - fy) * mirror_pixel(x0, y0)
            + fx * (unit - fy) * mirror_pixel(x1, y0)
            + (unit - fx) * fy * mirror_pixel(x0, y1)
            + fx * fy * mirror_pixel(x1, y1);
        sum = ((sum << SHL) + RND) >> SHR;
        res.sample_value  = sum[VALUE_W-1:0];
        res.outside_image = 1'b0;
        return res;
    endfunction

    function automatic int active_radius();
        int r;
        r = int'(radius_reg);
        if (r > MAX_RADIUS)
            r = MAX_RADIUS;
        return r;
    endfunction

    // update the store copy or queue the expected patch
    function automatic void predict_request(input t_req req);
        int     r, total, n;
        longint unit;
        t_res   res;
        if (req.cmd == CMD_WRITE) begin
            write_count++;
            if (req.pixel_col < IMAGE_WIDTH && req.pixel_row < IMAGE_HEIGHT) begin
                pixel_mirror[req.pixel_row * IMAGE_WIDTH + req.pixel_col] = req.pixel_value;
                pixel_loaded[req.pixel_row * IMAGE_WIDTH + req.pixel_col] = 1'b1;
            end
            return;
        end
        sample_count++;
        r     = active_radius();
        total = (2 * r + 1) * (2 * r + 1);
        unit  = longint'(1) << FRAC_BITS;
        n     = 0;
        radius_used[r] = 1'b1;
        for (int dx = -r; dx <= r; dx++) begin
            for (int dy = -r; dy <= r; dy++) begin
                res = blend_point(longint'(req.centre_x) + dx * unit,
                                  longint'(req.centre_y) + dy * unit);
                n++;
                res.last_sample = (n == total);
                expected_blends = {expected_blends, res};
            end
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe) begin
            got_res = o_res;
            if (expected_blends.size() == 0) begin
                $error("result with nothing expected: value %0h outside %0b last %0b",
                       got_res.sample_value, got_res.outside_image, got_res.last_sample);
                error_count++;
            end else begin
                want_res = expected_blends.pop_front();
                results_checked++;
                if (got_res.sample_value !== want_res.sample_value) begin
                    $error("sample_value: expected %0h, got %0h",
                           want_res.sample_value, got_res.sample_value);
                    error_count++;
                end
                if (got_res.outside_image !== want_res.outside_image) begin
                    $error("outside_image: expected %0b, got %0b",
                           want_res.outside_image, got_res.outside_image);
                    error_count++;
                end
                if (got_res.last_sample !== want_res.last_sample) begin
                    $error("last_sample: expected %0b, got %0b",
                           want_res.last_sample, got_res.last_sample);
                    error_count++;
                end
            end
        end
    end

    // present one request and hold it until accepted
    task automatic issue_request(input t_req req);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        request_count++;
        predict_request(req);
    endtask

    task automatic load_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                              input logic [PIX_W-1:0] value);
        t_req req;
        req             = '0;
        req.cmd         = CMD_WRITE;
        req.pixel_col   = col;
        req.pixel_row   = row;
        req.pixel_value = value;
        req.centre_x    = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
        req.centre_y    = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
        issue_request(req);
    endtask

    // load every pixel the patch will read that holds nothing yet
    task automatic preload_patch(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy);
        int     r, x0, y0, x1, y1;
        longint unit, fx, fy;
        int     cols [4];
        int     rows [4];
        r    = active_radius();
        unit = longint'(1) << FRAC_BITS;
        for (int dx = -r; dx <= r; dx++) begin
            for (int dy = -r; dy <= r; dy++) begin
                if (neighbour_cell(longint'(cx) + dx * unit, longint'(cy) + dy * unit,
                                   x0, y0, x1, y1, fx, fy)) begin
                    cols = '{x0, x1, x0, x1};
                    rows = '{y0, y0, y1, y1};
                    for (int k = 0; k < 4; k++)
                        if (!pixel_loaded[rows[k] * IMAGE_WIDTH + cols[k]])
                            load_pixel(COL_W'(cols[k]), ROW_W'(rows[k]),
                                       PIX_W'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    task automatic sample_patch(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy);
        t_req req;
        preload_patch(cx, cy);
        req             = '0;
        req.cmd         = CMD_SAMPLE;
        req.pixel_col   = COL_W'($urandom_range(0, (1 << COL_W) - 1));
        req.pixel_row   = ROW_W'($urandom_range(0, (1 << ROW_W) - 1));
        req.pixel_value = PIX_W'($urandom_range(0, (1 << PIX_W) - 1));
        req.centre_x    = cx;
        req.centre_y    = cy;
        issue_request(req);
    endtask

    // stop requesting, let all results arrive, then settle
    task automatic wait_for_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_blends.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_radius(input logic [RADIUS_W-1:0] radius);
        wait_for_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= radius;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        radius_reg = radius;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // centre drawn mostly near the image corners and middle
    function automatic logic [COORD_W-1:0] pick_centre_coord();
        int     zone;
        longint v;
        zone = $urandom_range(0, 99);
        if (zone < 4)
            v = $urandom_range(0, (1 << COORD_W) - 1);
        else if (zone < 50)
            v = $urandom_range(0, 12 << FRAC_BITS);
        else if (zone < 80)
            v = $urandom_range((1 << COORD_W) - 1 - (12 << FRAC_BITS), (1 << COORD_W) - 1);
        else
            v = $urandom_range(250 << FRAC_BITS, 262 << FRAC_BITS);
        // integer centres make all four neighbours the same pixel
        if ($urandom_range(0, 3) == 0)
            v = v & ~((longint'(1) << FRAC_BITS) - 1);
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [COL_W-1:0] pick_pixel_coord();
        int zone;
        zone = $urandom_range(0, 99);
        if (zone < 35)
            return COL_W'($urandom_range(0, 14));
        else if (zone < 70)
            return COL_W'($urandom_range(IMAGE_WIDTH - 15, IMAGE_WIDTH - 1));
        else if (zone < 85)
            return COL_W'($urandom_range(248, 264));
        return COL_W'($urandom_range(0, (1 << COL_W) - 1));
    endfunction

    task automatic random_traffic(input int n_requests);
        int stop_at;
        stop_at = request_count + n_requests;
        while (request_count < stop_at) begin
            if ($urandom_range(0, 99) < 45)
                sample_patch(pick_centre_coord(), pick_centre_coord());
            else
                load_pixel(pick_pixel_coord(), pick_pixel_coord(),
                           PIX_W'($urandom_range(0, 255)));
        end
    endtask

    // radius after reset is 2
    task automatic test_reset_radius();
        sample_patch(17'h00280, 17'h00240);
        sample_patch(17'h00300, 17'h00300);
    endtask

    // corner pixels, fraction extremes and positions past the image edge
    task automatic test_directed_edges();
        set_radius(2'd0);
        load_pixel(9'd0, 9'd0, 8'd255);
        load_pixel(9'd1, 9'd0, 8'd0);
        load_pixel(9'd0, 9'd1, 8'd0);
        load_pixel(9'd1, 9'd1, 8'd255);
        load_pixel(9'd511, 9'd511, 8'd255);
        load_pixel(9'd510, 9'd511, 8'd0);
        load_pixel(9'd511, 9'd510, 8'd128);
        load_pixel(9'd510, 9'd510, 8'd1);
        sample_patch(17'h00000, 17'h00000);
        sample_patch(17'h00080, 17'h00080);
        sample_patch(17'h000FF, 17'h00001);
        sample_patch(17'h1FF00, 17'h1FF00);
        sample_patch(17'h1FEFF, 17'h1FEFF);
        sample_patch(17'h1FFFF, 17'h00000);
        sample_patch(17'h00000, 17'h1FFFF);
        set_radius(2'd3);
        sample_patch(17'h00000, 17'h00000);
        sample_patch(17'h1FFFF, 17'h1FFFF);
        sample_patch(17'h00300, 17'h00300);
    endtask

    task automatic test_radius_sweep();
        logic [RADIUS_W-1:0] sweep [4];
        sweep = '{2'd1, 2'd3, 2'd0, 2'd2};
        foreach (sweep[i]) begin
            set_radius(sweep[i]);
            random_traffic(60);
        end
    endtask

    // requests offered every cycle, held while the sampler is busy
    task automatic test_back_to_back();
        set_radius(2'd3);
        gaps_on = 1'b0;
        random_traffic(60);
        gaps_on = 1'b1;
    endtask

    // main sequence
    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_radius();
        test_directed_edges();
        test_radius_sweep();
        test_back_to_back();
        wait_for_idle();

        $display("%0d requests: %0d pixel writes, %0d patch samples, %0d results checked",
                 request_count, write_count, sample_count, results_checked);
        $display("patch radii exercised (bit per radius): %b, %0d cycles",
                 radius_used, cycle_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
